/* rtl/pfa_pkg.sv */
// shared types and constants for the partition fit allocator
// no dependencies; used by every file of the block
package pfa_pkg;

  localparam int DEF_MAX_PARTITIONS = 128;
  localparam int DEF_SIZE_BITS      = 16;

  localparam int IDX_PORT_W  = 7;
  localparam int SIZE_PORT_W = 16;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int POLICY_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ALLOCATION_POLICY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PARTITION_COUNT   = 1'b1;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   granted;
    logic [IDX_PORT_W-1:0]  chosen_index;
    logic [SIZE_PORT_W-1:0] size_before;
    logic [SIZE_PORT_W-1:0] size_after;
  } result_t;

endpackage

/* rtl/pfa_table.sv */
// free size table: one write port, one registered read port
// depends on pfa_pkg for default sizes
module pfa_table #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_PARTITIONS)-1:0] wr_addr,
  input  logic [SIZE_BITS-1:0]              wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_PARTITIONS)-1:0] rd_addr,
  output logic [SIZE_BITS-1:0]              rd_data
);

  logic [SIZE_BITS-1:0] mem [MAX_PARTITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pfa_ctrl.sv */
// scan sequencer: walks the table one entry a cycle through a shared compare
// unit, then writes back the reduced size; depends on pfa_pkg and pfa_table
module pfa_ctrl #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_fire,
  input  logic                                   cmd,
  input  logic [pfa_pkg::IDX_PORT_W-1:0]         entry_index,
  input  logic [pfa_pkg::SIZE_PORT_W-1:0]        entry_size,
  input  logic [pfa_pkg::SIZE_PORT_W-1:0]        request_size,
  input  pfa_pkg::policy_t                       policy,
  input  logic [$clog2(MAX_PARTITIONS+1)-1:0]    n,
  input  logic                                   res_ready,
  output logic                                   busy,
  output logic                                   res_valid,
  output pfa_pkg::result_t                       res
);

  localparam int IDX_W       = $clog2(MAX_PARTITIONS);
  localparam int CNT_W       = $clog2(MAX_PARTITIONS + 1);
  localparam int IDX_PORT_W  = pfa_pkg::IDX_PORT_W;
  localparam int SIZE_PORT_W = pfa_pkg::SIZE_PORT_W;

  pfa_pkg::state_t state, state_next;

  logic [SIZE_BITS-1:0] need, best_val, rd_data, wr_data, after;
  logic [IDX_W-1:0]     cursor, issue_pos, rd_pos, best_pos, start_pos, issue_pos_inc, wr_addr;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_vld, found;
  logic                 first_like, hit, better, take, stop, issue, scan_end;
  logic                 in_table, load_wr, alloc_start, wb_wr, wr_en;

  always_comb begin
    first_like    = (policy == pfa_pkg::POL_FIRST) || (policy == pfa_pkg::POL_NEXT);
    hit           = rd_vld && (rd_data >= need);
    better        = (policy == pfa_pkg::POL_BEST) ? (rd_data < best_val) : (rd_data > best_val);
    stop          = first_like && hit;
    take          = hit && (first_like || !found || better);
    issue         = (state == pfa_pkg::ST_SCAN) && !stop && (issue_cnt != n);
    scan_end      = (state == pfa_pkg::ST_SCAN) && !stop && (issue_cnt == n) && !rd_vld;
    in_table      = 32'(entry_index) < MAX_PARTITIONS;
    load_wr       = (state == pfa_pkg::ST_IDLE) && in_fire && (cmd == pfa_pkg::CMD_LOAD)
                    && in_table;
    alloc_start   = (state == pfa_pkg::ST_IDLE) && in_fire && (cmd == pfa_pkg::CMD_ALLOC);
    wb_wr         = (state == pfa_pkg::ST_DONE) && res_ready && found;
    start_pos     = ((policy == pfa_pkg::POL_NEXT) && (CNT_W'(cursor) < n)) ? cursor : '0;
    issue_pos_inc = ((CNT_W'(issue_pos) + CNT_W'(1)) == n) ? '0 : issue_pos + IDX_W'(1);
    after         = best_val - need;
    wr_en         = load_wr || wb_wr;
    wr_addr       = wb_wr ? best_pos : IDX_W'(entry_index);
    wr_data       = wb_wr ? after : SIZE_BITS'(entry_size);
  end

  pfa_table #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (issue_pos),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != pfa_pkg::ST_IDLE);
    res_valid  = 1'b0;
    unique case (state)
      pfa_pkg::ST_IDLE: begin
        if (alloc_start) begin
          state_next = pfa_pkg::ST_SCAN;
        end
      end
      pfa_pkg::ST_SCAN: begin
        if (stop || scan_end) begin
          state_next = pfa_pkg::ST_DONE;
        end
      end
      pfa_pkg::ST_DONE: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.granted      = found;
    res.chosen_index = found ? IDX_PORT_W'(best_pos) : '0;
    res.size_before  = found ? SIZE_PORT_W'(best_val) : '0;
    res.size_after   = found ? SIZE_PORT_W'(after) : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
      cursor <= '0;
    end else begin
      rd_vld <= issue;
      if (alloc_start) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (alloc_start && (policy == pfa_pkg::POL_NEXT)) begin
        cursor <= start_pos;
      end else if (wb_wr && (policy == pfa_pkg::POL_NEXT)) begin
        cursor <= best_pos;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (alloc_start) begin
      need      <= SIZE_BITS'(request_size);
      issue_pos <= start_pos;
      issue_cnt <= '0;
    end else if (issue) begin
      issue_pos <= issue_pos_inc;
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
    if (issue) begin
      rd_pos <= issue_pos;
    end
    if (take) begin
      best_pos <= rd_pos;
      best_val <= rd_data;
    end
  end

endmodule

/* rtl/partition_fit_allocator.sv */
// Partition fit allocator. A load item writes one free size into the table. An
// allocate item scans the partitions in use one entry per cycle through the
// single table read port, picks a slot by the policy register (first, next
// from a kept cursor, smallest or largest that fits, ties to the lowest
// index), subtracts the request and returns one result item. An allocate
// keeps the input stalled while it scans up to n entries, n being
// partition_count capped at the table size, and while its result waits for
// the output register to drain; first and next fit stop at the first slot
// that fits. The result sits in an output register, so a load may be taken
// while it waits. Entries must be loaded before an allocate scans them.
// Depends on pfa_pkg and pfa_ctrl.
module partition_fit_allocator #(
  parameter int MAX_PARTITIONS = pfa_pkg::DEF_MAX_PARTITIONS,
  parameter int SIZE_BITS      = pfa_pkg::DEF_SIZE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [pfa_pkg::IDX_PORT_W-1:0]     entry_index,
  input  logic [pfa_pkg::SIZE_PORT_W-1:0]    entry_size,
  input  logic [pfa_pkg::SIZE_PORT_W-1:0]    request_size,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               granted,
  output logic [pfa_pkg::IDX_PORT_W-1:0]     chosen_index,
  output logic [pfa_pkg::SIZE_PORT_W-1:0]    size_before,
  output logic [pfa_pkg::SIZE_PORT_W-1:0]    size_after
);

  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  pfa_pkg::policy_t                 policy;
  logic [pfa_pkg::CFG_DATA_W-1:0]   partition_count;
  logic [CNT_W-1:0]                 n;
  logic                             in_fire, busy, res_valid, res_ready;
  pfa_pkg::result_t                 res, out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy          <= pfa_pkg::POL_FIRST;
      partition_count <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pfa_pkg::REG_ALLOCATION_POLICY: begin
          policy <= pfa_pkg::policy_t'(cfg_data[pfa_pkg::POLICY_W-1:0]);
        end
        pfa_pkg::REG_PARTITION_COUNT: begin
          partition_count <= cfg_data;
        end
        default: begin
          policy <= policy;
        end
      endcase
    end
  end

  always_comb begin
    if (32'(partition_count) > MAX_PARTITIONS) begin
      n = CNT_W'(MAX_PARTITIONS);
    end else begin
      n = CNT_W'(partition_count);
    end
    in_stall  = busy;
    in_fire   = in_valid && !busy;
    res_ready = !out_valid || !out_stall;
  end

  pfa_ctrl #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_size   (entry_size),
    .request_size (request_size),
    .policy       (policy),
    .n            (n),
    .res_ready    (res_ready),
    .busy         (busy),
    .res_valid    (res_valid),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  always_comb begin
    granted      = out_res.granted;
    chosen_index = out_res.chosen_index;
    size_before  = out_res.size_before;
    size_after   = out_res.size_after;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_ready)
    else $error("result issued while output register full");

  a_alloc_stalls: assert property (@(posedge clk) disable iff (rst)
    in_fire && (cmd == pfa_pkg::CMD_ALLOC) |=> in_stall)
    else $error("allocate item did not start a scan");

  a_refusal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> (chosen_index == '0) && (size_before == '0)
                              && (size_after == '0))
    else $error("refused item carries nonzero fields");

  a_grant_shrinks: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> size_after <= size_before)
    else $error("granted size grew");

endmodule
